### design/fsgd_pkg.sv
// shared widths, register indexes, reset values and output levels for the grayscale dither block
package fsgd_pkg;

   // fixed field widths
   localparam int PIXEL_W    = 8;
   localparam int LINE_W_W   = 11;
   localparam int THR_W      = 8;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'b1;

   // register reset values
   localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 11'd1024;
   localparam logic [THR_W-1:0]    THRESHOLD_RST  = 8'd127;

   // output levels
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'd0;

endpackage

### design/fsgd_req_if.sv
// input pixel channel: valid/ready with pixel and frame start
interface fsgd_req_if import fsgd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;
   logic               frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

### design/fsgd_rsp_if.sv
// dithered pixel channel: valid/ready with the binary pixel
interface fsgd_rsp_if import fsgd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

### design/fsgd_csr_if.sv
// register write channel: valid/ready with register index and data
interface fsgd_csr_if import fsgd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output idx, output data, input ready);
   modport sink   (input valid, input idx, input data, output ready);
endinterface

### design/floyd_steinberg_gray_dither_top.sv
// path: an accepted pixel and its store read are captured in the compute stage, then registered for rsp.
// throughput: one pixel per clock while rsp does not stall, held by the right-carry loop
// in the compute stage and by the single write port of the line store.
// reset: line width 1024, threshold 127, first row of a frame, all carries zero.
// the line store is not cleared; the first row of each frame reads it as zero.
// no clearing pass, so pixels are accepted from the first cycle after reset.
module floyd_steinberg_gray_dither_top import fsgd_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int FRAC_BITS = 4
) (
   input logic         clock,
   input logic         reset,
   fsgd_req_if.sink    req_ch,
   fsgd_rsp_if.source  rsp_ch,
   fsgd_csr_if.sink    csr_ch
);

   localparam int ERR_BITS = FRAC_BITS + 10;
   localparam int ADJ_W    = ERR_BITS + 2;
   localparam int PROD_W   = ERR_BITS + 4;
   localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W    = (WID_W > LINE_W_W) ? WID_W : LINE_W_W;

   localparam logic signed [ADJ_W-1:0] ADJ_MAX = ADJ_W'((1 << (ERR_BITS - 1)) - 1);
   localparam logic signed [ADJ_W-1:0] ADJ_MIN = ADJ_W'(-(1 << (ERR_BITS - 1)));

   // configuration registers
   logic [LINE_W_W-1:0] line_width_ff;
   logic [THR_W-1:0]    threshold_ff;

   // accept-side row tracking
   logic [COL_W-1:0] column_index_ff, column_index_in;
   logic             on_first_row_ff, on_first_row_in;

   // compute stage
   logic                       s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]         s1_pixel_ff;
   logic [COL_W-1:0]           s1_col_ff;
   logic                       s1_last_ff;
   logic                       s1_first_ff;
   logic                       s1_fs_ff;
   logic                       s1_fwd_hit_ff;
   logic signed [ERR_BITS-1:0] s1_fwd_data_ff;
   logic signed [ERR_BITS-1:0] mem_rd_ff;

   // error carries held across pixels
   logic signed [ERR_BITS-1:0] carry_right_ff, carry_right_in;
   logic signed [ERR_BITS-1:0] pend_left_ff, pend_left_in;
   logic signed [ERR_BITS-1:0] pend_below_ff, pend_below_in;

   // last column's below entry, parked until the next column-0 pixel frees the write port
   logic                       tail_valid_ff, tail_valid_in;
   logic [COL_W-1:0]           tail_addr_ff, tail_addr_in;
   logic signed [ERR_BITS-1:0] tail_data_ff, tail_data_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   // line store
   logic signed [ERR_BITS-1:0] line_mem [MAX_WIDTH];

   logic                       req_accept;
   logic                       s1_fire;
   logic [COL_W-1:0]           col_cur;
   logic                       first_cur;
   logic                       last_cur;
   logic [CMP_W-1:0]           lw_ext;
   logic [CMP_W-1:0]           wid_eff;

   logic signed [ERR_BITS-1:0] below_val;
   logic signed [ERR_BITS-1:0] carry_eff;
   logic signed [ERR_BITS-1:0] pend_left_eff;
   logic signed [ERR_BITS-1:0] pend_below_eff;
   logic signed [ADJ_W-1:0]    pix_x;
   logic signed [ADJ_W-1:0]    adj_raw;
   logic signed [ADJ_W-1:0]    adj_sat;
   logic signed [ERR_BITS-1:0] adj;
   logic signed [ERR_BITS-1:0] thr_x;
   logic                       white;
   logic signed [ERR_BITS:0]   err;
   logic signed [PROD_W-1:0]   err_x;
   logic signed [PROD_W-1:0]   p3, p5, p7;
   logic signed [ERR_BITS-1:0] sh1, sh3, sh5, sh7;

   logic                       wr_en;
   logic [COL_W-1:0]           wr_addr;
   logic signed [ERR_BITS-1:0] wr_data;

   // handshakes
   assign csr_ch.ready   = 1'b1;
   assign s1_fire        = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready   = ~s1_valid_ff | s1_fire;
   assign req_accept     = req_ch.valid & req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.pixel_out = rsp_pixel_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RST;
         threshold_ff  <= THRESHOLD_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.idx)
            CSR_LINE_WIDTH: line_width_ff <= csr_ch.data[LINE_W_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_ch.data[THR_W-1:0];
         endcase
      end
   end

   // effective row width, clamped to 1..MAX_WIDTH
   always_comb begin
      lw_ext = CMP_W'(line_width_ff);
      if (lw_ext == '0) begin
         wid_eff = CMP_W'(1);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         wid_eff = CMP_W'(MAX_WIDTH);
      end else begin
         wid_eff = lw_ext;
      end
   end

   // column and row of the incoming beat
   assign col_cur   = req_ch.frame_start ? '0 : column_index_ff;
   assign first_cur = req_ch.frame_start | on_first_row_ff;
   assign last_cur  = (CMP_W'(col_cur) + CMP_W'(1)) >= wid_eff;

   always_comb begin
      column_index_in = column_index_ff;
      on_first_row_in = on_first_row_ff;
      if (req_accept) begin
         if (last_cur) begin
            column_index_in = '0;
            on_first_row_in = 1'b0;
         end else begin
            column_index_in = col_cur + COL_W'(1);
            on_first_row_in = first_cur;
         end
      end
   end

   // below-row error: newest source wins (parked tail, then write at read time, then store)
   always_comb begin
      if (s1_first_ff) begin
         below_val = '0;
      end else if (tail_valid_ff && tail_addr_ff == s1_col_ff) begin
         below_val = tail_data_ff;
      end else if (s1_fwd_hit_ff) begin
         below_val = s1_fwd_data_ff;
      end else begin
         below_val = mem_rd_ff;
      end
   end

   // frame start drops the carries of the aborted row
   assign carry_eff      = s1_fs_ff ? '0 : carry_right_ff;
   assign pend_left_eff  = s1_fs_ff ? '0 : pend_left_ff;
   assign pend_below_eff = s1_fs_ff ? '0 : pend_below_ff;

   // adjusted value with saturation
   assign pix_x   = ADJ_W'({s1_pixel_ff, {FRAC_BITS{1'b0}}});
   assign adj_raw = pix_x + ADJ_W'(carry_eff) + ADJ_W'(below_val);

   always_comb begin
      if (adj_raw > ADJ_MAX) begin
         adj_sat = ADJ_MAX;
      end else if (adj_raw < ADJ_MIN) begin
         adj_sat = ADJ_MIN;
      end else begin
         adj_sat = adj_raw;
      end
   end

   assign adj   = adj_sat[ERR_BITS-1:0];
   assign thr_x = ERR_BITS'({threshold_ff, {FRAC_BITS{1'b0}}});
   assign white = adj > thr_x;
   assign err   = white ? ((ERR_BITS+1)'(adj) - (ERR_BITS+1)'({PIXEL_WHITE, {FRAC_BITS{1'b0}}}))
                        : (ERR_BITS+1)'(adj);

   // error shares, floor of err*w/16
   assign err_x = PROD_W'(err);
   assign p3    = (err_x <<< 1) + err_x;
   assign p5    = (err_x <<< 2) + err_x;
   assign p7    = (err_x <<< 3) - err_x;
   assign sh1   = err_x[PROD_W-1:4];
   assign sh3   = p3[PROD_W-1:4];
   assign sh5   = p5[PROD_W-1:4];
   assign sh7   = p7[PROD_W-1:4];

   // store write: finished below-left entry, or the parked tail at column 0
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_col_ff - COL_W'(1);
      wr_data = pend_left_eff + sh3;
      if (s1_fire) begin
         if (s1_col_ff != '0) begin
            wr_en = 1'b1;
         end else if (tail_valid_ff) begin
            wr_en   = 1'b1;
            wr_addr = tail_addr_ff;
            wr_data = tail_data_ff;
         end
      end
   end

   // next carries and parked tail
   always_comb begin
      carry_right_in = carry_right_ff;
      pend_left_in   = pend_left_ff;
      pend_below_in  = pend_below_ff;
      tail_valid_in  = tail_valid_ff;
      tail_addr_in   = tail_addr_ff;
      tail_data_in   = tail_data_ff;
      if (s1_fire) begin
         if (s1_col_ff == '0 && tail_valid_ff) begin
            tail_valid_in = 1'b0;
         end
         if (s1_last_ff) begin
            carry_right_in = '0;
            pend_left_in   = '0;
            pend_below_in  = '0;
            tail_valid_in  = 1'b1;
            tail_addr_in   = s1_col_ff;
            tail_data_in   = pend_below_eff + sh5;
         end else begin
            carry_right_in = sh7;
            pend_left_in   = pend_below_eff + sh5;
            pend_below_in  = sh1;
         end
      end
   end

   // stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         on_first_row_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         carry_right_ff  <= '0;
         pend_left_ff    <= '0;
         pend_below_ff   <= '0;
         tail_valid_ff   <= 1'b0;
      end else begin
         column_index_ff <= column_index_in;
         on_first_row_ff <= on_first_row_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         carry_right_ff  <= carry_right_in;
         pend_left_ff    <= pend_left_in;
         pend_below_ff   <= pend_below_in;
         tail_valid_ff   <= tail_valid_in;
      end
   end

   // tail payload
   always_ff @(posedge clock) begin
      tail_addr_ff <= tail_addr_in;
      tail_data_ff <= tail_data_in;
   end

   // beat capture into the compute stage, with forward of the same-edge store write
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_ch.pixel_in;
         s1_col_ff      <= col_cur;
         s1_last_ff     <= last_cur;
         s1_first_ff    <= first_cur;
         s1_fs_ff       <= req_ch.frame_start;
         s1_fwd_hit_ff  <= wr_en && (wr_addr == col_cur);
         s1_fwd_data_ff <= wr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pixel_ff <= white ? PIXEL_WHITE : PIXEL_BLACK;
      end
   end

   // line store read port
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem_rd_ff <= line_mem[col_cur];
      end
   end

   // line store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

endmodule
